FILE: rtl/flp_pkg.sv
`default_nettype none

package flp_pkg;

  localparam int LEN_W      = 22;
  localparam int CNT_W      = 7;
  localparam int SEG_W      = 8;
  localparam int WIN_W      = 16;
  localparam int FIDX_W     = 5;
  localparam int SHIFT_W    = 32;

  localparam int DEF_MAX_SEGMENTS = 64;
  localparam logic [WIN_W-1:0] WIN_RESET = 16'd8192;

  localparam logic [7:0]         IMG_MAGIC     = 8'hE9;
  localparam logic [FIDX_W-1:0]  HDR_LAST_IDX  = 5'd23;
  localparam logic [WIN_W-1:0]   HDR_BYTES     = 16'd24;
  localparam logic [FIDX_W-1:0]  LEN_FIRST_IDX = 5'd4;
  localparam logic [FIDX_W-1:0]  SEG_LAST_IDX  = 5'd7;
  localparam logic [LEN_W:0]     SEG_HDR_BYTES = 23'd8;
  localparam logic [SHIFT_W-1:0] MAX_SEG_LEN   = 32'h0020_0000;
  localparam logic [LEN_W-1:0]   PAD_ROUND     = 22'd16;
  localparam logic [LEN_W-1:0]   PAD_MASK      = 22'h3F_FFF0;
  localparam logic [LEN_W-1:0]   HASH_BYTES    = 22'd32;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_SEGHDR,
    PH_SKIP
  } flp_phase_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_WIN_SMALL   = 3'd1,
    ST_BAD_MAGIC   = 3'd2,
    ST_BAD_COUNT   = 3'd3,
    ST_HDR_OUTSIDE = 3'd4,
    ST_BAD_LEN     = 3'd5
  } flp_status_t;

  typedef struct packed {
    logic              vld;
    logic [LEN_W-1:0]  image_length;
    logic [CNT_W-1:0]  seg_count;
    flp_status_t       status;
  } flp_res_t;

endpackage

`default_nettype wire

FILE: rtl/flp_core.sv
`default_nettype none

module flp_core #(
  parameter int MAX_SEGMENTS = flp_pkg::DEF_MAX_SEGMENTS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       step,
  input  wire logic [7:0]                 data_byte,
  input  wire logic                       start_req,
  input  wire logic [flp_pkg::WIN_W-1:0]  window,
  output flp_pkg::flp_res_t               res
);
  import flp_pkg::*;

  localparam logic [SEG_W-1:0] MaxSeg = SEG_W'(MAX_SEGMENTS);

  flp_phase_t          phase_r, phase_nxt, cur_phase;
  logic [LEN_W-1:0]    off_r, off_nxt, cur_off, off_inc;
  logic [FIDX_W-1:0]   fi_r, fi_nxt, cur_fi;
  logic [SEG_W-1:0]    tot_r, tot_nxt, cur_tot;
  logic [SEG_W-1:0]    done_r, done_nxt, cur_done, done_inc;
  logic                hash_r, hash_nxt, cur_hash;
  logic [SHIFT_W-1:0]  len_r, len_nxt, cur_len, len_upd;
  logic [LEN_W-1:0]    skip_r, skip_nxt, cur_skip, skip_dec;
  logic                outside;
  logic [LEN_W-1:0]    len_pad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      off_r   <= '0;
      fi_r    <= '0;
      tot_r   <= '0;
      done_r  <= '0;
      hash_r  <= 1'b0;
      len_r   <= '0;
      skip_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      fi_r    <= fi_nxt;
      tot_r   <= tot_nxt;
      done_r  <= done_nxt;
      hash_r  <= hash_nxt;
      len_r   <= len_nxt;
      skip_r  <= skip_nxt;
    end
  end

  always_comb begin
    cur_phase = phase_r;
    cur_off   = off_r;
    cur_fi    = fi_r;
    cur_tot   = tot_r;
    cur_done  = done_r;
    cur_hash  = hash_r;
    cur_len   = len_r;
    cur_skip  = skip_r;
    if (start_req) begin
      cur_phase = PH_HEADER;
      cur_off   = '0;
      cur_fi    = '0;
      cur_tot   = '0;
      cur_done  = '0;
      cur_hash  = 1'b0;
      cur_len   = '0;
      cur_skip  = '0;
    end

    off_inc  = cur_off + LEN_W'(1);
    outside  = ({1'b0, off_inc} + SEG_HDR_BYTES) > {{(LEN_W + 1 - WIN_W){1'b0}}, window};
    len_upd  = (cur_fi >= LEN_FIRST_IDX) ? {data_byte, cur_len[SHIFT_W-1:8]} : cur_len;
    skip_dec = (cur_skip != '0) ? cur_skip - LEN_W'(1) : cur_skip;
    done_inc = cur_done + SEG_W'(1);
    len_pad  = (off_inc + PAD_ROUND) & PAD_MASK;

    phase_nxt = cur_phase;
    off_nxt   = cur_off;
    fi_nxt    = cur_fi;
    tot_nxt   = cur_tot;
    done_nxt  = cur_done;
    hash_nxt  = cur_hash;
    len_nxt   = cur_len;
    skip_nxt  = cur_skip;
    res       = '0;

    if (start_req && (window < HDR_BYTES)) begin
      res.vld    = 1'b1;
      res.status = ST_WIN_SMALL;
      phase_nxt  = PH_IDLE;
    end else begin
      unique case (cur_phase)
        PH_IDLE: begin
        end
        PH_HEADER: begin
          off_nxt = off_inc;
          if ((cur_fi == '0) && (data_byte != IMG_MAGIC)) begin
            res.vld    = 1'b1;
            res.status = ST_BAD_MAGIC;
            phase_nxt  = PH_IDLE;
          end else if ((cur_fi == FIDX_W'(1)) && ((data_byte == '0) || (data_byte > MaxSeg))) begin
            res.vld    = 1'b1;
            res.status = ST_BAD_COUNT;
            phase_nxt  = PH_IDLE;
          end else begin
            if (cur_fi == FIDX_W'(1)) begin
              tot_nxt = data_byte;
            end
            if (cur_fi == HDR_LAST_IDX) begin
              hash_nxt = (data_byte != '0);
              done_nxt = '0;
              if (outside) begin
                res.vld    = 1'b1;
                res.status = ST_HDR_OUTSIDE;
                phase_nxt  = PH_IDLE;
              end else begin
                fi_nxt    = '0;
                len_nxt   = '0;
                phase_nxt = PH_SEGHDR;
              end
            end else begin
              fi_nxt = cur_fi + FIDX_W'(1);
            end
          end
        end
        PH_SEGHDR: begin
          off_nxt = off_inc;
          len_nxt = len_upd;
          fi_nxt  = cur_fi + FIDX_W'(1);
          if (cur_fi >= SEG_LAST_IDX) begin
            if ((len_upd == '0) || (len_upd > MAX_SEG_LEN)) begin
              res.vld    = 1'b1;
              res.status = ST_BAD_LEN;
              phase_nxt  = PH_IDLE;
            end else begin
              skip_nxt  = len_upd[LEN_W-1:0];
              phase_nxt = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          off_nxt  = off_inc;
          skip_nxt = skip_dec;
          if (skip_dec == '0) begin
            done_nxt = done_inc;
            if (done_inc >= cur_tot) begin
              res.vld          = 1'b1;
              res.status       = ST_OK;
              res.image_length = cur_hash ? len_pad + HASH_BYTES : len_pad;
              res.seg_count    = cur_tot[CNT_W-1:0];
              phase_nxt        = PH_IDLE;
            end else if (outside) begin
              res.vld    = 1'b1;
              res.status = ST_HDR_OUTSIDE;
              phase_nxt  = PH_IDLE;
            end else begin
              fi_nxt    = '0;
              len_nxt   = '0;
              phase_nxt = PH_SEGHDR;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SKIP) |-> (skip_r != '0))
    else $error("skip phase entered with nothing left to skip");

  a_seghdr_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SEGHDR) |-> (fi_r <= SEG_LAST_IDX))
    else $error("segment header index ran past its last byte");

  a_ok_padded: assert property (@(posedge clk) disable iff (!rst_n)
    (res.vld && (res.status == ST_OK)) |-> (res.image_length[3:0] == 4'd0))
    else $error("successful length is not padded to 16 bytes");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res.vld && (res.status != ST_OK)) |->
      ((res.image_length == '0) && (res.seg_count == '0)))
    else $error("error result carries a nonzero length or count");

  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.vld) |=> (phase_r == PH_IDLE))
    else $error("parser kept running after a result");

endmodule

`default_nettype wire

FILE: rtl/firmware_image_length_parser.sv
// Firmware image length parser.
//
// Image bytes enter on the in_ channel, one word per byte, in offset order;
// in_start_req marks the byte at offset zero and restarts any parse underway.
// The out_ channel carries one word per parse: the padded image length, the
// segment count and a status code, with length and count zero on any error.
// A result appears on the byte where the outcome is decided; bytes after it
// are dropped until the next start. The cfg_ channel writes the window size
// and is always ready; the user must write it only while the parser is idle,
// which the block itself does not enforce.
// An accepted byte is held in an input register and evaluated from there;
// a result that it decides is written into the output register, which drives
// the outputs. One byte per cycle is sustained while the output register is
// free or being taken: the input register is refilled in the same cycle that
// its byte is evaluated.
// When the receiver stalls, the held result stays on the outputs and the
// parser keeps its byte until the output register frees, so in_ready drops.
// Reset empties both registers, returns the parser to idle and sets the
// window to 8192 bytes.
`default_nettype none

module firmware_image_length_parser #(
  parameter int MAX_SEGMENTS = flp_pkg::DEF_MAX_SEGMENTS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [7:0]                 in_data_byte,
  input  wire logic                       in_start_req,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [flp_pkg::LEN_W-1:0]       out_image_length,
  output logic [flp_pkg::CNT_W-1:0]       out_seg_count,
  output logic [2:0]                      out_status,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [flp_pkg::WIN_W-1:0]  cfg_window_bytes
);
  import flp_pkg::*;

  logic              in_vld_r, in_vld_nxt;
  logic [7:0]        in_byte_r;
  logic              in_start_r;
  logic              fire;
  logic              out_vld_r, out_vld_nxt;
  logic [LEN_W-1:0]  out_len_r;
  logic [CNT_W-1:0]  out_cnt_r;
  flp_status_t       out_status_r;
  logic [WIN_W-1:0]  window_r;
  flp_res_t          res;

  assign fire       = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready   = !in_vld_r || fire;
  assign cfg_ready  = 1'b1;
  assign in_vld_nxt = (in_valid && in_ready) || (in_vld_r && !fire);
  assign out_vld_nxt = (fire && res.vld) ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      window_r  <= WIN_RESET;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        window_r <= cfg_window_bytes;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r  <= in_data_byte;
      in_start_r <= in_start_req;
    end
    if (fire && res.vld) begin
      out_len_r    <= res.image_length;
      out_cnt_r    <= res.seg_count;
      out_status_r <= res.status;
    end
  end

  flp_core #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (fire),
    .data_byte (in_byte_r),
    .start_req (in_start_r),
    .window    (window_r),
    .res       (res)
  );

  assign out_valid        = out_vld_r;
  assign out_image_length = out_len_r;
  assign out_seg_count    = out_cnt_r;
  assign out_status       = out_status_r;

endmodule

`default_nettype wire
